[rtl/core/gray_world_white_balance_core_defines.svh]
// ----------------------------------------------------------------------------
// Gray-world white balance assertion macros
// Shared concurrent assertion wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef GRAY_WORLD_WHITE_BALANCE_CORE_DEFINES_SVH
`define GRAY_WORLD_WHITE_BALANCE_CORE_DEFINES_SVH

// always active, also during reset
`define GWB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// inactive while reset is high
`define GWB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

[rtl/core/gwb_pkg.sv]
// ----------------------------------------------------------------------------
// gwb_pkg
// Types and constants shared by the gray-world white balance core.
// ----------------------------------------------------------------------------
package gwb_pkg;

  localparam int MAX_PIXELS = 65536;
  localparam int PIX_W      = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CNT_W      = PIX_W + 1;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int PX_W       = CH_W * NUM_CH;
  localparam int SUM_W      = CNT_W + 7;

  localparam logic       FUNC_LOAD = 1'b0;
  localparam logic       FUNC_READ = 1'b1;
  localparam logic [1:0] STEP_LAST = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN_INIT,
    ST_MEAN,
    ST_MEAN_WB,
    ST_FETCH,
    ST_BAL,
    ST_DONE
  } gwb_state_t;

  typedef struct packed {
    logic       clear;
    logic       acc;
    logic       mean_start;
    logic       bal_start;
    logic       iter;
    logic       mean_latch;
    logic [1:0] step;
  } gwb_ctrl_t;

endpackage

[rtl/core/gwb_lane.sv]
// ----------------------------------------------------------------------------
// gwb_lane
// One color channel: running sum, mean register and a radix-4 restoring
// divider producing an 8-bit quotient for the mean and the balanced value.
// ----------------------------------------------------------------------------
module gwb_lane
  import gwb_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  gwb_ctrl_t       ctrl,
  input  logic [CH_W-1:0] pix_in,
  input  logic [CH_W-1:0] rd_pix,
  input  logic [CNT_W-1:0] count,
  output logic [CH_W-1:0] result
);

  logic [SUM_W-1:0] sum;
  logic [CH_W-1:0]  mean;
  logic [SUM_W-1:0] rem;
  logic [SUM_W-1:0] rem_next;
  logic [CNT_W-1:0] dvs;
  logic [CH_W-1:0]  quo;
  logic [CH_W-1:0]  quo_next;
  logic             sat;
  logic             zero;

  logic [SUM_W-1:0] dsh_hi;
  logic [SUM_W-1:0] dsh_lo;
  logic [SUM_W-1:0] rem_mid;
  logic             bit_hi;
  logic             bit_lo;

  always_comb begin
    dsh_hi   = SUM_W'(dvs) << {ctrl.step, 1'b1};
    dsh_lo   = SUM_W'(dvs) << {ctrl.step, 1'b0};
    bit_hi   = (rem >= dsh_hi);
    rem_mid  = bit_hi ? (rem - dsh_hi) : rem;
    bit_lo   = (rem_mid >= dsh_lo);
    rem_next = bit_lo ? (rem_mid - dsh_lo) : rem_mid;
    quo_next = quo | (CH_W'(bit_hi) << {ctrl.step, 1'b1})
                   | (CH_W'(bit_lo) << {ctrl.step, 1'b0});
    result   = sat ? {CH_W{1'b1}} : (zero ? '0 : quo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum  <= '0;
      mean <= '0;
    end else begin
      if (ctrl.clear || ctrl.acc) begin
        sum <= (ctrl.clear ? '0 : sum) + (ctrl.acc ? SUM_W'(pix_in) : '0);
      end
      if (ctrl.mean_latch) begin
        mean <= result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mean_start) begin
      rem  <= sum;
      dvs  <= count;
      quo  <= '0;
      sat  <= 1'b0;
      zero <= (count == '0);
    end else if (ctrl.bal_start) begin
      rem  <= SUM_W'({rd_pix, 7'b0});
      dvs  <= CNT_W'(mean);
      quo  <= '0;
      zero <= (rd_pix == '0);
      sat  <= (rd_pix != '0) &&
              ((mean == '0) || ({1'b0, rd_pix} >= {mean, 1'b0}));
    end else if (ctrl.iter) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

endmodule

[rtl/core/gwb_merge.sv]
// ----------------------------------------------------------------------------
// gwb_merge
// Combines the three lane results into one pixel in the output register.
// ----------------------------------------------------------------------------
module gwb_merge
  import gwb_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic [CH_W-1:0] res [NUM_CH],
  input  logic            last_in,
  output logic            free,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [PX_W-1:0] m_tdata,
  output logic            m_tlast
);

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NUM_CH; i++) begin
        m_tdata[CH_W*i +: CH_W] <= res[i];
      end
      m_tlast <= last_in;
    end
  end

endmodule

[rtl/core/gray_world_white_balance_core.sv]
// Load: one transaction per cycle while idle. After a frame end, input is held
// off by the mean pass of the 4-step radix-4 divider in each channel lane.
// Readout: the store read, divider setup, 4 divider steps and output load run
// in order before the next transaction is taken; output stalls hold it off.
// Reset is synchronous: clears control, sums, means and counts; the frame
// store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// gray_world_white_balance_core
// Gray-world white balance: frame store, control FSM, three channel lanes
// and the output merge stage.
// ----------------------------------------------------------------------------
module gray_world_white_balance_core
  import gwb_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [PX_W-1:0] s_tdata,   // blue_in, green_in, red_in
  input  logic            s_tuser,   // func
  input  logic            s_tlast,   // frame_end
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [PX_W-1:0] m_tdata,   // blue_out, green_out, red_out
  output logic            m_tlast    // last_out
);

  gwb_state_t       state;
  gwb_state_t       state_next;
  gwb_ctrl_t        ctrl;
  logic [1:0]       step;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] base_count;
  logic [CNT_W-1:0] rp;
  logic             frame_ready;
  logic             last_pend;
  logic             load_ok;
  logic             rd_ok;
  logic             rd_en;
  logic             out_load;
  logic             out_free;
  logic [PX_W-1:0]  rd_data;
  logic [CH_W-1:0]  res [NUM_CH];

  logic [PX_W-1:0]  mem [MAX_PIXELS];

  assign base_count = frame_ready ? '0 : count;
  assign load_ok    = (base_count < CNT_W'(MAX_PIXELS));
  assign rd_ok      = frame_ready && (rp < count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    ctrl.step  = step;
    s_tready   = 1'b0;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == FUNC_LOAD) begin
            ctrl.clear = frame_ready;
            ctrl.acc   = load_ok;
            if (s_tlast) begin
              state_next = ST_MEAN_INIT;
            end
          end else if (rd_ok) begin
            rd_en      = 1'b1;
            state_next = ST_FETCH;
          end
        end
      end
      ST_MEAN_INIT: begin
        ctrl.mean_start = 1'b1;
        state_next      = ST_MEAN;
      end
      ST_MEAN: begin
        ctrl.iter = 1'b1;
        if (step == '0) begin
          state_next = ST_MEAN_WB;
        end
      end
      ST_MEAN_WB: begin
        ctrl.mean_latch = 1'b1;
        state_next      = ST_IDLE;
      end
      ST_FETCH: begin
        ctrl.bal_start = 1'b1;
        state_next     = ST_BAL;
      end
      ST_BAL: begin
        ctrl.iter = 1'b1;
        if (step == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      rp          <= '0;
      frame_ready <= 1'b0;
      step        <= '0;
    end else begin
      if (ctrl.mean_start || ctrl.bal_start) begin
        step <= STEP_LAST;
      end else if (ctrl.iter) begin
        step <= step - 2'd1;
      end
      if (s_tvalid && s_tready && (s_tuser == FUNC_LOAD)) begin
        count       <= base_count + CNT_W'(load_ok);
        rp          <= '0;
        frame_ready <= s_tlast;
      end else if (rd_en) begin
        rp <= rp + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      last_pend <= ((rp + CNT_W'(1)) == count);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc) begin
      mem[base_count[PIX_W-1:0]] <= s_tdata;
    end
    if (rd_en) begin
      rd_data <= mem[rp[PIX_W-1:0]];
    end
  end

  for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
    gwb_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .pix_in (s_tdata[CH_W*i +: CH_W]),
      .rd_pix (rd_data[CH_W*i +: CH_W]),
      .count  (count),
      .result (res[i])
    );
  end

  gwb_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .res      (res),
    .last_in  (last_pend),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

[rtl/core/gwb_checker.sv]
// ----------------------------------------------------------------------------
// gwb_checker
// Port-level checks on the white balance core, bound to the top level.
// ----------------------------------------------------------------------------
`include "gray_world_white_balance_core_defines.svh"

module gwb_checker
  import gwb_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            s_tvalid,
  input logic            s_tready,
  input logic            m_tvalid,
  input logic            m_tready,
  input logic [PX_W-1:0] m_tdata,
  input logic            m_tlast
);

  `GWB_ASSERT_ALWAYS(a_rst_idle, rst |=> !m_tvalid, "output valid after reset")
  `GWB_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
  `GWB_ASSERT(a_no_fast, s_tvalid && s_tready |=> !$rose(m_tvalid), "result one cycle after transaction")
  `GWB_ASSERT(a_busy_rise, $rose(m_tvalid) |-> $past(!s_tready), "result rose while input side idle")

endmodule

bind gray_world_white_balance_core gwb_checker u_gwb_checker (.*);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: gray-world white balance core testbench
// Streams BGR frames into the core, predicts every balanced pixel from the
// channel means of the frame, and compares each result transaction with
// the oldest prediction under varying handshake stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gwb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] r;
    logic            last;
  } bal_px_t;

  logic            clk;
  logic            rst;
  logic            s_tvalid;
  logic            s_tready;
  logic [PX_W-1:0] s_tdata;   // blue_in, green_in, red_in
  logic            s_tuser;   // func
  logic            s_tlast;   // frame_end
  logic            m_tvalid;
  logic            m_tready;
  logic [PX_W-1:0] m_tdata;   // blue_out, green_out, red_out
  logic            m_tlast;   // last_out

  // predictor state
  logic [PX_W-1:0] gw_frame_px [MAX_PIXELS];
  longint unsigned gw_sum [NUM_CH];
  logic [CH_W-1:0] gw_mean [NUM_CH];
  int unsigned     gw_count;
  int unsigned     gw_rd_ptr;
  logic            gw_ready;
  bal_px_t         balanced_q [$];

  int src_idle_pct;
  int snk_idle_pct;
  int mismatches;
  int n_loads;
  int n_frames;
  int n_checked;
  int stall_cycles;

  gray_world_white_balance_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [CH_W-1:0] scale_channel(logic [CH_W-1:0] v, logic [CH_W-1:0] m);
    int unsigned q;
    if (m == 0) begin
      return (v != 0) ? 8'd255 : 8'd0;
    end
    q = (128 * v) / m;
    return (q > 255) ? 8'd255 : q[CH_W-1:0];
  endfunction

  task automatic predict_balance(input logic func, input logic [CH_W-1:0] b, g, r,
                                 input logic fe);
    logic [PX_W-1:0] word;
    bal_px_t px;
    int k;
    if (func == FUNC_LOAD) begin
      if (gw_ready) begin
        for (k = 0; k < NUM_CH; k++) begin
          gw_sum[k] = 0;
          gw_mean[k] = '0;
        end
        gw_count = 0;
        gw_rd_ptr = 0;
        gw_ready = 1'b0;
      end
      if (gw_count < MAX_PIXELS) begin
        gw_frame_px[gw_count] = {r, g, b};
        gw_sum[0] += b;
        gw_sum[1] += g;
        gw_sum[2] += r;
        gw_count++;
      end
      if (fe) begin
        for (k = 0; k < NUM_CH; k++) begin
          gw_mean[k] = CH_W'(gw_sum[k] / gw_count);
        end
        gw_rd_ptr = 0;
        gw_ready = 1'b1;
        n_frames++;
      end
      n_loads++;
    end else if (gw_ready && gw_rd_ptr < gw_count) begin
      word = gw_frame_px[gw_rd_ptr];
      px.b = scale_channel(word[7:0], gw_mean[0]);
      px.g = scale_channel(word[15:8], gw_mean[1]);
      px.r = scale_channel(word[23:16], gw_mean[2]);
      px.last = (gw_rd_ptr + 1 == gw_count);
      gw_rd_ptr++;
      balanced_q.push_back(px);
    end
  endtask

  // one input transaction; returns at the falling edge after acceptance
  task automatic push_item(input logic func, input logic [CH_W-1:0] b, g, r, input logic fe);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {r, g, b};
    s_tlast  <= fe;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_balance(func, b, g, r, fe);
    @(negedge clk);
  endtask

  function automatic void check_field(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    bal_px_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_checked++;
      if (balanced_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, expected nothing, actual %h last %b",
                 $time, m_tdata, m_tlast);
      end else begin
        want = balanced_q.pop_front();
        check_field("blue_out", want.b, m_tdata[7:0]);
        check_field("green_out", want.g, m_tdata[15:8]);
        check_field("red_out", want.r, m_tdata[23:16]);
        check_field("last_out", {7'd0, want.last}, {7'd0, m_tlast});
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // readouts before any frame end and past the last pixel give nothing
  task automatic test_readout_gating();
    push_item(FUNC_READ, 8'd255, 8'd255, 8'd255, 1'b1);
    push_item(FUNC_READ, 8'd0, 8'd0, 8'd0, 1'b0);
    push_item(FUNC_LOAD, 8'd10, 8'd20, 8'd30, 1'b0);
    push_item(FUNC_READ, 8'd1, 8'd2, 8'd3, 1'b0);
    push_item(FUNC_LOAD, 8'd30, 8'd40, 8'd50, 1'b1);
    repeat (3) push_item(FUNC_READ, 8'd0, 8'd0, 8'd0, 1'b0);
  endtask

  task automatic test_single_pixel_frames();
    push_item(FUNC_LOAD, 8'd255, 8'd255, 8'd255, 1'b1);
    push_item(FUNC_READ, 8'd0, 8'd0, 8'd0, 1'b0);
    push_item(FUNC_LOAD, 8'd0, 8'd0, 8'd0, 1'b1);
    push_item(FUNC_READ, 8'd0, 8'd0, 8'd0, 1'b0);
  endtask

  // zero means on blue and red, saturation on green
  task automatic test_zero_mean_saturation();
    push_item(FUNC_LOAD, 8'd1, 8'd255, 8'd0, 1'b0);
    push_item(FUNC_LOAD, 8'd0, 8'd1, 8'd0, 1'b0);
    push_item(FUNC_LOAD, 8'd0, 8'd0, 8'd0, 1'b1);
    repeat (3) push_item(FUNC_READ, 8'd0, 8'd0, 8'd0, 1'b0);
  endtask

  // readout fields ignored; a load mid-readout starts a new frame
  task automatic test_readout_fields_and_restart();
    push_item(FUNC_LOAD, 8'd128, 8'd64, 8'd200, 1'b0);
    push_item(FUNC_LOAD, 8'd0, 8'd192, 8'd255, 1'b1);
    push_item(FUNC_READ, 8'd255, 8'd255, 8'd255, 1'b1);
    push_item(FUNC_LOAD, 8'd7, 8'd7, 8'd7, 1'b1);
    push_item(FUNC_READ, 8'd0, 8'd0, 8'd0, 1'b0);
  endtask

  task automatic test_random_frames(input int budget);
    int done;
    int n;
    int mode;
    int zc;
    int k;
    int reads;
    logic [CH_W-1:0] b, g, r;
    done = 0;
    while (done < budget) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      mode = $urandom_range(3);
      zc = $urandom_range(2);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(19) == 0) begin
          push_item(FUNC_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        case (mode)
          0: begin
            b = 8'($urandom_range(255));
            g = 8'($urandom_range(255));
            r = 8'($urandom_range(255));
          end
          1: begin
            b = 8'($urandom_range(7));
            g = 8'($urandom_range(7));
            r = 8'($urandom_range(7));
          end
          2: begin
            b = (zc == 0) ? 8'd0 : 8'($urandom_range(255));
            g = (zc == 1) ? 8'd0 : 8'($urandom_range(255));
            r = (zc == 2) ? 8'd0 : 8'($urandom_range(255));
          end
          default: begin
            b = 8'($urandom_range(192, 255));
            g = 8'($urandom_range(192, 255));
            r = 8'($urandom_range(192, 255));
          end
        endcase
        push_item(FUNC_LOAD, b, g, r, k == n - 1);
        done++;
      end
      reads = ($urandom_range(6) == 0) ? $urandom_range(0, n - 1) : n + $urandom_range(0, 2);
      for (k = 0; k < reads; k++) begin
        push_item(FUNC_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      done += reads;
    end
  endtask

  initial begin
    int k;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = FUNC_LOAD;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    mismatches = 0;
    n_loads = 0;
    n_frames = 0;
    n_checked = 0;
    stall_cycles = 0;
    for (k = 0; k < NUM_CH; k++) begin
      gw_sum[k] = 0;
      gw_mean[k] = '0;
    end
    gw_count = 0;
    gw_rd_ptr = 0;
    gw_ready = 1'b0;
    src_idle_pct = 31;
    snk_idle_pct = 65;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_readout_gating();
    test_single_pixel_frames();
    test_zero_mean_saturation();
    test_readout_fields_and_restart();
    test_random_frames(600);
    src_idle_pct = 65;
    snk_idle_pct = 31;
    test_random_frames(600);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_frames(590);
    s_tvalid <= 1'b0;

    while (balanced_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (balanced_q.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected pixels never arrived", $time, balanced_q.size());
    end
    $display("covered %0d pixel loads in %0d frames, with gated and surplus readouts",
             n_loads, n_frames);
    $display("compared %0d balanced pixels under three stall mixes", n_checked);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
